FILE: hdl/kwm_pkg.sv
// Package for the k-way sorted merge: defaults, request and status codes, state type.
`timescale 1ns / 1ps
package kwm_pkg;

  localparam int NUM_LISTS_DEF  = 8;
  localparam int LIST_DEPTH_DEF = 64;
  localparam int VALUE_BITS_DEF = 32;

  // request kind
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TAKE = 1'b1;

  // result status
  localparam logic [1:0] STATUS_LOADED = 2'd0;
  localparam logic [1:0] STATUS_TAKEN  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;
  localparam logic [1:0] STATUS_FULL   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REFILL
  } state_t;

endpackage

FILE: hdl/k_way_sorted_merge.sv
// Top level of the k-way sorted merge: per-list FIFOs in one RAM, head registers, min tree.
`timescale 1ns / 1ps
// A request is accepted only in IDLE; its result is registered on leaving EXEC.
// Sequence: a load passes through IDLE and EXEC; a take passes through IDLE, EXEC and
//   REFILL when the popped list still holds entries (the new head is read from the list
//   RAM, registered read), else IDLE and EXEC. A stalled output register holds EXEC.
// Reset (synchronous, rst_n low): all lists empty, pointers zero, no result pending.
//   The list RAM is not cleared; only written entries are ever read.
module k_way_sorted_merge #(
  parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
  parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_BITS = kwm_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [2:0]         in_list_index,
  input  logic signed [31:0] in_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_merged_value,
  output logic [2:0]         out_source_list
);

  // stored value width: values are held at most 32 bits wide
  localparam int EB    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int LW    = $clog2(NUM_LISTS);
  localparam int P     = 1 << LW;                 // min tree leaves, padded
  localparam int PW    = $clog2(LIST_DEPTH);
  localparam int FW    = $clog2(LIST_DEPTH + 1);
  localparam int DEPTH = NUM_LISTS * LIST_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  // RAM address of a slot of a list
  function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] list,
                                              input logic [PW-1:0] slot);
    slot_addr = AW'(list) * AW'(LIST_DEPTH) + AW'(slot);
  endfunction

  // slot pointers wrap from the last slot back to zero
  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    next_slot = (p == PW'(LIST_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  kwm_pkg::state_t state_r, state_nxt;

  // accepted request
  logic                 kind_r;
  logic [2:0]           idx_r;
  logic signed [EB-1:0] val_r;

  // per-list control state
  logic [PW-1:0] rd_ptr_r [NUM_LISTS];
  logic [PW-1:0] wr_ptr_r [NUM_LISTS];
  logic [FW-1:0] fill_r   [NUM_LISTS];

  // cached head of each list; valid whenever the list is not empty, except in REFILL
  logic signed [EB-1:0] head_r [NUM_LISTS];

  // registered minimum over the heads
  logic                 best_vld_r;
  logic signed [EB-1:0] best_val_r;
  logic [LW-1:0]        best_idx_r;

  logic [LW-1:0] refill_list_r;

  // output register
  logic                 out_vld_r;
  logic [1:0]           out_status_r;
  logic signed [EB-1:0] out_val_r;
  logic [LW-1:0]        out_src_r;

  // control from the state machine
  logic          do_load, do_take, do_refill, out_load, out_free;
  logic [1:0]    res_status;
  logic [LW-1:0] ld_list;
  logic          ld_ok, ld_full;

  // RAM ports
  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [EB-1:0] ram_rd_data;

  // min tree: level 0 holds the heads, each level picks the smaller of a pair,
  // the left (lower list) on a tie
  logic                 tv   [LW+1][P];
  logic signed [EB-1:0] tval [LW+1][P];
  logic [LW-1:0]        tidx [LW+1][P];

  for (genvar g = 0; g < P; g++) begin : g_leaf
    if (g < NUM_LISTS) begin : g_real
      assign tv[0][g]   = (fill_r[g] != '0);
      assign tval[0][g] = head_r[g];
    end else begin : g_pad
      assign tv[0][g]   = 1'b0;
      assign tval[0][g] = '0;
    end
    assign tidx[0][g] = LW'(g);
  end

  for (genvar l = 0; l < LW; l++) begin : g_lvl
    for (genvar n = 0; n < (P >> (l + 1)); n++) begin : g_node
      logic pick_hi;
      assign pick_hi = tv[l][2*n+1] && (!tv[l][2*n] || (tval[l][2*n+1] < tval[l][2*n]));
      assign tv[l+1][n]   = tv[l][2*n] || tv[l][2*n+1];
      assign tval[l+1][n] = pick_hi ? tval[l][2*n+1] : tval[l][2*n];
      assign tidx[l+1][n] = pick_hi ? tidx[l][2*n+1] : tidx[l][2*n];
    end
  end

  // load target check
  assign ld_list  = LW'(idx_r);
  assign ld_ok    = (32'(idx_r) < NUM_LISTS);
  assign ld_full  = ld_ok && (fill_r[ld_list] == FW'(LIST_DEPTH));
  assign out_free = !out_vld_r || !out_stall;

  // state machine: next state and control
  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    do_load    = 1'b0;
    do_take    = 1'b0;
    do_refill  = 1'b0;
    out_load   = 1'b0;
    res_status = kwm_pkg::STATUS_EMPTY;
    case (state_r)
      kwm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = kwm_pkg::ST_EXEC;
        end
      end
      kwm_pkg::ST_EXEC: begin
        // wait here while the previous result is still held
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = kwm_pkg::ST_IDLE;
          if (kind_r == kwm_pkg::KIND_LOAD) begin
            if (ld_ok && !ld_full) begin
              do_load    = 1'b1;
              res_status = kwm_pkg::STATUS_LOADED;
            end else begin
              res_status = kwm_pkg::STATUS_FULL;
            end
          end else if (best_vld_r) begin
            do_take    = 1'b1;
            res_status = kwm_pkg::STATUS_TAKEN;
            if (fill_r[best_idx_r] > FW'(1)) begin
              do_refill = 1'b1;
              state_nxt = kwm_pkg::ST_REFILL;
            end
          end else begin
            res_status = kwm_pkg::STATUS_EMPTY;
          end
        end
      end
      kwm_pkg::ST_REFILL: begin
        state_nxt = kwm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = kwm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kwm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (state_r == kwm_pkg::ST_IDLE && in_valid) begin
      kind_r <= in_kind;
      idx_r  <= in_list_index;
      val_r  <= in_value[EB-1:0];
    end
  end

  // list RAM accesses: a load appends at the write pointer, a take with entries left
  // fetches the slot after the current head
  assign ram_wr_en   = do_load;
  assign ram_wr_addr = slot_addr(ld_list, wr_ptr_r[ld_list]);
  assign ram_rd_en   = do_refill;
  assign ram_rd_addr = slot_addr(best_idx_r, next_slot(rd_ptr_r[best_idx_r]));

  kwm_ram #(
    .WIDTH (EB),
    .DEPTH (DEPTH)
  ) u_list_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (val_r),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // pointers and fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_LISTS; k++) begin
        rd_ptr_r[k] <= '0;
        wr_ptr_r[k] <= '0;
        fill_r[k]   <= '0;
      end
    end else if (do_load) begin
      wr_ptr_r[ld_list] <= next_slot(wr_ptr_r[ld_list]);
      fill_r[ld_list]   <= fill_r[ld_list] + FW'(1);
    end else if (do_take) begin
      rd_ptr_r[best_idx_r] <= next_slot(rd_ptr_r[best_idx_r]);
      fill_r[best_idx_r]   <= fill_r[best_idx_r] - FW'(1);
    end
  end

  // head cache: a load into an empty list becomes its head at once,
  // otherwise the head comes back from the RAM in the REFILL state after a take
  always_ff @(posedge clk) begin
    if (do_load && fill_r[ld_list] == '0) begin
      head_r[ld_list] <= val_r;
    end
    if (do_refill) begin
      refill_list_r <= best_idx_r;
    end
    if (state_r == kwm_pkg::ST_REFILL) begin
      head_r[refill_list_r] <= ram_rd_data;
    end
  end

  // minimum registered every cycle; a head written in EXEC or REFILL is in it by the next EXEC
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else begin
      best_vld_r <= tv[LW][0];
    end
    best_val_r <= tval[LW][0];
    best_idx_r <= tidx[LW][0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
    if (out_load) begin
      out_status_r <= res_status;
      out_val_r    <= do_take ? best_val_r : '0;
      out_src_r    <= do_take ? best_idx_r : '0;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = out_status_r;
  assign out_merged_value = 32'(out_val_r);
  assign out_source_list  = 3'(out_src_r);

endmodule

FILE: hdl/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kwm_ram #(
  parameter int WIDTH = kwm_pkg::VALUE_BITS_DEF,
  parameter int DEPTH = kwm_pkg::NUM_LISTS_DEF * kwm_pkg::LIST_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
